// ===== hw/rtl/mqttp_pkg.sv =====
package mqttp_pkg;

   // Default for the longest remaining-length field, in bytes
   localparam int MAX_LENGTH_BYTES_DEF = 4;

   localparam int BYTE_W   = 8;
   localparam int ROLE_W   = 3;
   localparam int LEN_W    = 28;
   localparam int IDENT_W  = 16;
   localparam int ERR_W    = 2;
   localparam int LCNT_W   = 3;
   localparam int RSP_W    = 72;

   // Byte roles reported on tuser
   localparam logic [ROLE_W-1:0] ROLE_HEADER  = 3'd0;
   localparam logic [ROLE_W-1:0] ROLE_LENGTH  = 3'd1;
   localparam logic [ROLE_W-1:0] ROLE_TLEN    = 3'd2;
   localparam logic [ROLE_W-1:0] ROLE_TOPIC   = 3'd3;
   localparam logic [ROLE_W-1:0] ROLE_IDENT   = 3'd4;
   localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 3'd5;
   localparam logic [ROLE_W-1:0] ROLE_BODY    = 3'd6;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LEN_LONG = 2'd1;
   localparam logic [ERR_W-1:0] ERR_SHORT    = 2'd2;

   // Control packet types
   localparam logic [3:0] PT_CONNACK  = 4'd2;
   localparam logic [3:0] PT_PUBLISH  = 4'd3;
   localparam logic [3:0] PT_PUBACK   = 4'd4;
   localparam logic [3:0] PT_PUBCOMP  = 4'd7;
   localparam logic [3:0] PT_SUBACK   = 4'd9;
   localparam logic [3:0] PT_UNSUBACK = 4'd11;

   typedef enum logic [6:0] {
      PH_HDR     = 7'b0000001,
      PH_LEN     = 7'b0000010,
      PH_TLEN    = 7'b0000100,
      PH_TOPIC   = 7'b0001000,
      PH_IDENT   = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_BODY    = 7'b1000000
   } phase_type;

   // Types whose body starts with a packet id
   function automatic logic is_ack(input logic [3:0] ptype);
      is_ack = ((ptype >= PT_PUBACK) && (ptype <= PT_PUBCOMP)) ||
               (ptype == PT_SUBACK) || (ptype == PT_UNSUBACK);
   endfunction

   // Types that carry required body fields
   function automatic logic needs_fields(input logic [3:0] ptype);
      needs_fields = (ptype == PT_CONNACK) || (ptype == PT_PUBLISH) || is_ack(ptype);
   endfunction

endpackage

// ===== hw/rtl/mqtt_packet_stream_parser_top.sv =====
// Channel   | Dir | Payload
// ----------+-----+-------------------------------------------------------------
// req_      | in  | tdata[7:0] raw stream byte
// rsp_      | out | tdata: byte, type, flags, length, packet id, id valid,
//           |     |        session present, return code, error; tuser: role;
//           |     |        tlast: last byte of packet
//
// One item per cycle sustained while rsp_tready is high; each result shows in the
// cycle after its byte is accepted. The single result register lies between: all
// decoding is one short pass of shift, add and counter logic from the byte to it.
// reset is synchronous and active high; it returns the parser to waiting for
// a header byte and empties the result register.
// A stalled result holds req_tready low only while the result register is full
// and rsp_tready is low.
module mqtt_packet_stream_parser_top #(
   parameter int MAX_LENGTH_BYTES = mqttp_pkg::MAX_LENGTH_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] byte_value, [11:8] packet_type, [15:12] header_flags,
   // [43:16] rem_length, [59:44] packet_ident, [60] ident_valid,
   // [61] sess_present, [69:62] ack_code, [71:70] error_code
   output logic [71:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] byte_role
   output logic        rsp_tlast    // last_of_packet
);

   // Parser state
   mqttp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  tf_ff, tf_in;            // type and flags of current packet
   logic [27:0] acc_ff, acc_in;          // remaining length accumulator
   logic [2:0]  lcnt_ff, lcnt_in;        // length bytes seen
   logic [27:0] left_ff, left_in;        // body bytes left
   logic [15:0] topic_ff, topic_in;      // topic bytes left
   logic [15:0] ident_ff, ident_in;
   logic [1:0]  fpos_ff, fpos_in;        // byte position within a two-byte field

   // Result register
   logic        rvalid_ff, rvalid_in;
   logic [71:0] rdata_ff, rdata_in;
   logic [2:0]  ruser_ff, ruser_in;
   logic        rlast_ff, rlast_in;

   logic        accept;
   logic [7:0]  b;
   logic [3:0]  ptype;
   logic [1:0]  qos;
   mqttp_pkg::phase_type after_topic;
   logic [27:0] addend;
   logic [2:0]  role;
   logic        last;
   logic [1:0]  err;
   logic        idv;
   logic        sp;
   logic [7:0]  rc;
   logic        in_body;
   logic [15:0] topic_full;

   assign req_tready = !rvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign ptype      = tf_ff[7:4];
   assign qos        = tf_ff[2:1];
   assign after_topic = (qos != 2'd0) ? mqttp_pkg::PH_IDENT : mqttp_pkg::PH_PAYLOAD;
   assign topic_full = topic_ff | {8'd0, b};

   // Place the low seven bits of a length byte at its group
   always_comb begin
      case (lcnt_ff[1:0])
         2'd0:    addend = {21'd0, b[6:0]};
         2'd1:    addend = {14'd0, b[6:0], 7'd0};
         2'd2:    addend = {7'd0, b[6:0], 14'd0};
         2'd3:    addend = {b[6:0], 21'd0};
         default: addend = 28'd0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      tf_in    = tf_ff;
      acc_in   = acc_ff;
      lcnt_in  = lcnt_ff;
      left_in  = left_ff;
      topic_in = topic_ff;
      ident_in = ident_ff;
      fpos_in  = fpos_ff;
      role     = mqttp_pkg::ROLE_BODY;
      last     = 1'b0;
      err      = mqttp_pkg::ERR_NONE;
      idv      = 1'b0;
      sp       = 1'b0;
      rc       = 8'd0;
      in_body  = 1'b1;

      case (phase_ff)
         mqttp_pkg::PH_LEN: begin
            in_body = 1'b0;
            role    = mqttp_pkg::ROLE_LENGTH;
            if (lcnt_ff < 3'd4) begin
               acc_in = acc_ff + addend;
            end
            lcnt_in = lcnt_ff + 3'd1;
            if (b[7]) begin
               // Continuation on the last allowed length byte: abandon packet
               if (lcnt_in >= 3'(MAX_LENGTH_BYTES)) begin
                  err      = mqttp_pkg::ERR_LEN_LONG;
                  last     = 1'b1;
                  phase_in = mqttp_pkg::PH_HDR;
               end
            end else begin
               left_in = acc_in;
               if (acc_in == 28'd0) begin
                  last     = 1'b1;
                  err      = mqttp_pkg::needs_fields(ptype) ? mqttp_pkg::ERR_SHORT
                                                           : mqttp_pkg::ERR_NONE;
                  phase_in = mqttp_pkg::PH_HDR;
               end else if (ptype == mqttp_pkg::PT_PUBLISH) begin
                  phase_in = mqttp_pkg::PH_TLEN;
               end else if (mqttp_pkg::is_ack(ptype)) begin
                  phase_in = mqttp_pkg::PH_IDENT;
               end else begin
                  phase_in = mqttp_pkg::PH_BODY;
               end
            end
         end
         mqttp_pkg::PH_TLEN: begin
            role = mqttp_pkg::ROLE_TLEN;
            if (fpos_ff == 2'd0) begin
               topic_in = {b, 8'd0};
               fpos_in  = 2'd1;
            end else begin
               topic_in = topic_full;
               fpos_in  = 2'd0;
               phase_in = (topic_full != 16'd0) ? mqttp_pkg::PH_TOPIC : after_topic;
            end
         end
         mqttp_pkg::PH_TOPIC: begin
            role     = mqttp_pkg::ROLE_TOPIC;
            topic_in = topic_ff - 16'd1;
            if (topic_in == 16'd0) begin
               phase_in = after_topic;
            end
         end
         mqttp_pkg::PH_IDENT: begin
            role = mqttp_pkg::ROLE_IDENT;
            if (fpos_ff == 2'd0) begin
               ident_in = {b, 8'd0};
               fpos_in  = 2'd1;
            end else begin
               ident_in = ident_ff | {8'd0, b};
               fpos_in  = 2'd0;
               idv      = 1'b1;
               phase_in = (ptype == mqttp_pkg::PT_PUBLISH) ? mqttp_pkg::PH_PAYLOAD
                                                          : mqttp_pkg::PH_BODY;
            end
         end
         mqttp_pkg::PH_PAYLOAD: begin
            role = mqttp_pkg::ROLE_PAYLOAD;
         end
         mqttp_pkg::PH_BODY: begin
            role = mqttp_pkg::ROLE_BODY;
            if (ptype == mqttp_pkg::PT_CONNACK) begin
               if (fpos_ff == 2'd0) begin
                  ident_in = {8'd0, b};
                  sp       = b[0];
                  fpos_in  = 2'd1;
               end else if (fpos_ff == 2'd1) begin
                  sp      = ident_ff[0];
                  rc      = b;
                  fpos_in = 2'd2;
               end
            end
         end
         default: begin
            // Header byte, also taken from any unused phase code
            in_body  = 1'b0;
            role     = mqttp_pkg::ROLE_HEADER;
            tf_in    = b;
            acc_in   = 28'd0;
            lcnt_in  = 3'd0;
            left_in  = 28'd0;
            topic_in = 16'd0;
            ident_in = 16'd0;
            fpos_in  = 2'd0;
            phase_in = mqttp_pkg::PH_LEN;
         end
      endcase

      // Count body bytes down to the packet end
      if (in_body) begin
         left_in = left_ff - {27'd0, (left_ff != 28'd0)};
         if (left_in == 28'd0) begin
            last = 1'b1;
            if ((phase_in == mqttp_pkg::PH_TLEN) || (phase_in == mqttp_pkg::PH_TOPIC) ||
                (phase_in == mqttp_pkg::PH_IDENT) ||
                ((ptype == mqttp_pkg::PT_CONNACK) && (phase_in == mqttp_pkg::PH_BODY) &&
                 (fpos_in < 2'd2))) begin
               err = mqttp_pkg::ERR_SHORT;
            end
            phase_in = mqttp_pkg::PH_HDR;
         end
      end
   end

   // Build the result item from the updated state
   always_comb begin
      rdata_in = {err, rc, sp, idv, ident_in, acc_in, tf_in[3:0], tf_in[7:4], b};
      ruser_in = role;
      rlast_in = last;
      if (accept) begin
         rvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rvalid_in = 1'b0;
      end else begin
         rvalid_in = rvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mqttp_pkg::PH_HDR;
         tf_ff     <= 8'd0;
         acc_ff    <= 28'd0;
         lcnt_ff   <= 3'd0;
         left_ff   <= 28'd0;
         topic_ff  <= 16'd0;
         ident_ff  <= 16'd0;
         fpos_ff   <= 2'd0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= rvalid_in;
         if (accept) begin
            phase_ff <= phase_in;
            tf_ff    <= tf_in;
            acc_ff   <= acc_in;
            lcnt_ff  <= lcnt_in;
            left_ff  <= left_in;
            topic_ff <= topic_in;
            ident_ff <= ident_in;
            fpos_ff  <= fpos_in;
         end
      end
   end

   // Hold the payload while the result waits
   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff <= rdata_in;
         ruser_ff <= ruser_in;
         rlast_ff <= rlast_in;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;
   assign rsp_tlast  = rlast_ff;

endmodule

// ===== hw/rtl/mqttp_checker.sv =====
module mqttp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Any error ends the packet
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[71:70] != mqttp_pkg::ERR_NONE) |-> rsp_tlast)
      else $error("error without end of packet");

   // Overlong length is reported only on a length byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[71:70] == mqttp_pkg::ERR_LEN_LONG) |->
      (rsp_tuser == mqttp_pkg::ROLE_LENGTH))
      else $error("length error on a non-length byte");

   // A completed packet id comes only on a packet id byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[60] |-> (rsp_tuser == mqttp_pkg::ROLE_IDENT))
      else $error("id valid outside packet id");

   // A header byte starts from a cleared length and id
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mqttp_pkg::ROLE_HEADER) |->
      (rsp_tdata[43:16] == 28'd0) && (rsp_tdata[59:44] == 16'd0) && !rsp_tlast)
      else $error("header byte carries stale fields");

endmodule

bind mqtt_packet_stream_parser_top mqttp_checker u_mqttp_checker (.*);

// ===== bench/tb_mqtt_packet_stream_parser_top.sv =====
module tb_mqtt_packet_stream_parser_top;

   // Packet types the package leaves unnamed
   localparam logic [3:0] PT_RESERVED_LO = 4'd0;
   localparam logic [3:0] PT_CONNECT     = 4'd1;
   localparam logic [3:0] PT_PUBREC      = 4'd5;
   localparam logic [3:0] PT_PUBREL      = 4'd6;
   localparam logic [3:0] PT_SUBSCRIBE   = 4'd8;
   localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;
   localparam logic [3:0] PT_PINGREQ     = 4'd12;
   localparam logic [3:0] PT_PINGRESP    = 4'd13;
   localparam logic [3:0] PT_DISCONNECT  = 4'd14;
   localparam logic [3:0] PT_RESERVED_HI = 4'd15;

   localparam int         MAX_LEN_FIELD  = mqttp_pkg::MAX_LENGTH_BYTES_DEF;
   localparam logic [7:0] LEN_MORE       = 8'h80;   // continuation bit of a length byte
   localparam int         RANDOM_BYTES   = 530;
   localparam int         STALL_LIMIT    = 2000;    // cycles without any item moving
   localparam int         DRAIN_CYCLES   = 4;

   // One decoded stream byte, as the parser should report it
   typedef struct {
      logic [7:0]  value;
      logic [2:0]  role;
      logic [3:0]  ptype;
      logic [3:0]  flags;
      logic [27:0] rlen;
      logic [15:0] ident;
      logic        idv;
      logic        sp;
      logic [7:0]  rc;
      logic        last;
      logic [1:0]  err;
   } byte_report_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] byte_value, [11:8] packet_type, [15:12] header_flags,
   // [43:16] rem_length, [59:44] packet_ident, [60] ident_valid,
   // [61] sess_present, [69:62] ack_code, [71:70] error_code
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;            // [2:0] byte_role
   logic        rsp_tlast;            // last_of_packet

   mqtt_packet_stream_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stream bytes waiting to be sent, and the body of the frame being built
   logic [7:0]   stream_bytes[$];
   logic [7:0]   frame_body[$];
   // Reports owed by the parser, oldest first
   byte_report_type predicted_reports[$];

   // Parser state as predicted from the accepted bytes
   mqttp_pkg::phase_type cur_phase = mqttp_pkg::PH_HDR;
   logic [7:0]   hdr_byte    = 8'h00;
   logic [27:0]  len_acc     = '0;
   logic [2:0]   len_cnt     = '0;
   logic [27:0]  body_left   = '0;
   logic [15:0]  topic_cnt   = '0;
   logic [15:0]  id_reg      = '0;
   logic [1:0]   fpos        = '0;

   int           bytes_total;
   int           bytes_accepted  = 0;
   int           packets_framed  = 0;
   int           results_seen    = 0;
   int           mismatches      = 0;
   int           ends_seen       = 0;
   int           idents_seen     = 0;
   int           long_len_seen   = 0;
   int           short_body_seen = 0;
   int           quiet_cycles    = 0;
   int           send_hold       = 0;
   int           recv_hold       = 0;
   bit           send_steady     = 1'b0;
   bit           recv_steady     = 1'b0;
   byte_report_type sent_report;
   byte_report_type want;

   // ---------------------------------------------------------------------
   // Packet classes
   // ---------------------------------------------------------------------

   // Acks whose body opens with a packet id
   function automatic bit opens_with_ident(input logic [3:0] ptype);
      case (ptype)
         mqttp_pkg::PT_PUBACK, PT_PUBREC, PT_PUBREL, mqttp_pkg::PT_PUBCOMP,
         mqttp_pkg::PT_SUBACK, mqttp_pkg::PT_UNSUBACK: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Types that cannot legally carry an empty body
   function automatic bit requires_body_fields(input logic [3:0] ptype);
      return (ptype == mqttp_pkg::PT_CONNACK) || (ptype == mqttp_pkg::PT_PUBLISH) ||
             opens_with_ident(ptype);
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: advance the parser state by one byte, return its report
   // ---------------------------------------------------------------------
   task automatic parse_stream_byte(input logic [7:0] b, output byte_report_type r);
      logic [3:0] ptype;
      mqttp_pkg::phase_type after_topic;
      ptype = hdr_byte[7:4];
      // PUBLISH with any nonzero QoS (3 included) carries a packet id
      after_topic = (hdr_byte[2:1] != 2'd0) ? mqttp_pkg::PH_IDENT : mqttp_pkg::PH_PAYLOAD;
      r = '{value: b, role: mqttp_pkg::ROLE_BODY, err: mqttp_pkg::ERR_NONE, default: '0};

      case (cur_phase)
         mqttp_pkg::PH_HDR: begin
            // Latch type and flags, clear everything for the new packet
            hdr_byte  = b;
            len_acc   = '0;
            len_cnt   = '0;
            body_left = '0;
            topic_cnt = '0;
            id_reg    = '0;
            fpos      = '0;
            cur_phase = mqttp_pkg::PH_LEN;
            r.role    = mqttp_pkg::ROLE_HEADER;
         end
         mqttp_pkg::PH_LEN: begin
            r.role  = mqttp_pkg::ROLE_LENGTH;
            len_acc = len_acc + ({21'd0, b[6:0]} << (7 * len_cnt));
            len_cnt = len_cnt + 3'd1;
            if (b[7]) begin
               // Continuation on the last allowed length byte: abandon the packet
               if (len_cnt >= MAX_LEN_FIELD) begin
                  r.err     = mqttp_pkg::ERR_LEN_LONG;
                  r.last    = 1'b1;
                  cur_phase = mqttp_pkg::PH_HDR;
               end
            end else begin
               body_left = len_acc;
               if (body_left == 0) begin
                  r.last = 1'b1;
                  if (requires_body_fields(ptype))
                     r.err = mqttp_pkg::ERR_SHORT;
                  cur_phase = mqttp_pkg::PH_HDR;
               end else if (ptype == mqttp_pkg::PT_PUBLISH) begin
                  cur_phase = mqttp_pkg::PH_TLEN;
               end else if (opens_with_ident(ptype)) begin
                  cur_phase = mqttp_pkg::PH_IDENT;
               end else begin
                  cur_phase = mqttp_pkg::PH_BODY;
               end
            end
         end
         default: begin
            case (cur_phase)
               mqttp_pkg::PH_TLEN: begin
                  r.role = mqttp_pkg::ROLE_TLEN;
                  if (fpos == 2'd0) begin
                     topic_cnt = {b, 8'h00};
                     fpos      = 2'd1;
                  end else begin
                     topic_cnt[7:0] = b;
                     fpos           = 2'd0;
                     if (topic_cnt != 0)
                        cur_phase = mqttp_pkg::PH_TOPIC;
                     else
                        cur_phase = after_topic;
                  end
               end
               mqttp_pkg::PH_TOPIC: begin
                  r.role    = mqttp_pkg::ROLE_TOPIC;
                  topic_cnt = topic_cnt - 16'd1;
                  if (topic_cnt == 0)
                     cur_phase = after_topic;
               end
               mqttp_pkg::PH_IDENT: begin
                  r.role = mqttp_pkg::ROLE_IDENT;
                  if (fpos == 2'd0) begin
                     id_reg = {b, 8'h00};
                     fpos   = 2'd1;
                  end else begin
                     id_reg[7:0] = b;
                     fpos        = 2'd0;
                     r.idv       = 1'b1;
                     if (ptype == mqttp_pkg::PT_PUBLISH)
                        cur_phase = mqttp_pkg::PH_PAYLOAD;
                     else
                        cur_phase = mqttp_pkg::PH_BODY;
                  end
               end
               mqttp_pkg::PH_PAYLOAD: begin
                  r.role = mqttp_pkg::ROLE_PAYLOAD;
               end
               default: begin
                  r.role = mqttp_pkg::ROLE_BODY;
                  // CONNACK: flags byte then return code, later bytes plain body
                  if (ptype == mqttp_pkg::PT_CONNACK) begin
                     if (fpos == 2'd0) begin
                        id_reg = {8'h00, b};
                        r.sp   = b[0];
                        fpos   = 2'd1;
                     end else if (fpos == 2'd1) begin
                        r.sp = id_reg[0];
                        r.rc = b;
                        fpos = 2'd2;
                     end
                  end
               end
            endcase
            if (body_left != 0)
               body_left = body_left - 28'd1;
            if (body_left == 0) begin
               r.last = 1'b1;
               if (cur_phase == mqttp_pkg::PH_TLEN || cur_phase == mqttp_pkg::PH_TOPIC ||
                   cur_phase == mqttp_pkg::PH_IDENT ||
                   (ptype == mqttp_pkg::PT_CONNACK && cur_phase == mqttp_pkg::PH_BODY &&
                    fpos < 2'd2))
                  r.err = mqttp_pkg::ERR_SHORT;
               cur_phase = mqttp_pkg::PH_HDR;
            end
         end
      endcase

      r.ptype = hdr_byte[7:4];
      r.flags = hdr_byte[3:0];
      r.rlen  = len_acc;
      r.ident = id_reg;
   endtask

   // ---------------------------------------------------------------------
   // Stream building
   // ---------------------------------------------------------------------

   function automatic int shortest_length_field(input int unsigned len);
      int n;
      n = 1;
      while (n < MAX_LEN_FIELD && (len >> (7 * n)) != 0)
         n++;
      return n;
   endfunction

   // Queue header, length field and body; field_len of zero picks the shortest field
   task automatic send_frame(input logic [7:0] hdr, input int field_len);
      int          n;
      int unsigned len;
      len = frame_body.size();
      n   = (field_len != 0) ? field_len : shortest_length_field(len);
      stream_bytes.push_back(hdr);
      for (int i = 0; i < n; i++)
         stream_bytes.push_back({i < n - 1, 7'((len >> (7 * i)) & 32'h7F)});
      foreach (frame_body[i])
         stream_bytes.push_back(frame_body[i]);
      frame_body.delete();
      packets_framed++;
   endtask

   task automatic push_random_bytes(input int count);
      repeat (count) frame_body.push_back(8'($urandom));
   endtask

   // Mostly well-formed packets with random content; some truncated, some noise
   task automatic add_random_packet();
      int unsigned pick;
      int unsigned cut;
      int          field_len;
      logic [3:0]  ptype;
      logic [3:0]  flags;
      logic [15:0] tlen;
      bit          broken;
      pick   = $urandom_range(0, 99);
      flags  = 4'($urandom);
      broken = ($urandom_range(0, 99) < 12);
      frame_body.delete();

      if (pick < 4) begin
         // Runaway length field: continuation on every allowed byte
         stream_bytes.push_back({4'($urandom), flags});
         repeat (MAX_LEN_FIELD) stream_bytes.push_back(LEN_MORE | 8'($urandom_range(0, 127)));
         packets_framed++;
      end else begin
         if (pick < 34) begin
            ptype = mqttp_pkg::PT_PUBLISH;
            tlen  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
            frame_body.push_back(tlen[15:8]);
            frame_body.push_back(tlen[7:0]);
            // Long topic lengths are left unfinished by the frame end
            push_random_bytes((tlen > 8) ? 8 : tlen);
            if (flags[2:1] != 2'd0)
               push_random_bytes(2);
            push_random_bytes(($urandom_range(0, 19) == 0) ? $urandom_range(100, 180)
                                                            : $urandom_range(0, 10));
         end else if (pick < 50) begin
            ptype = mqttp_pkg::PT_CONNACK;
            frame_body.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 1)));
            frame_body.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 5)));
            if ($urandom_range(0, 9) == 0)
               push_random_bytes($urandom_range(1, 3));
         end else if (pick < 78) begin
            case ($urandom_range(0, 5))
               0: ptype = mqttp_pkg::PT_PUBACK;
               1: ptype = PT_PUBREC;
               2: ptype = PT_PUBREL;
               3: ptype = mqttp_pkg::PT_PUBCOMP;
               4: ptype = mqttp_pkg::PT_SUBACK;
               default: ptype = mqttp_pkg::PT_UNSUBACK;
            endcase
            push_random_bytes(2);
            if (ptype == mqttp_pkg::PT_SUBACK)
               push_random_bytes($urandom_range(0, 3));
         end else if (pick < 92) begin
            case ($urandom_range(0, 7))
               0: ptype = PT_CONNECT;
               1: ptype = PT_SUBSCRIBE;
               2: ptype = PT_UNSUBSCRIBE;
               3: ptype = PT_PINGREQ;
               4: ptype = PT_PINGRESP;
               5: ptype = PT_DISCONNECT;
               6: ptype = PT_RESERVED_LO;
               default: ptype = PT_RESERVED_HI;
            endcase
            push_random_bytes($urandom_range(0, 8));
         end else begin
            // Noise: any header byte, random body
            ptype = 4'($urandom);
            push_random_bytes($urandom_range(0, 8));
         end

         if (broken && frame_body.size() != 0) begin
            cut = $urandom_range(0, frame_body.size() - 1);
            while (frame_body.size() > cut)
               void'(frame_body.pop_back());
         end
         // Now and then spend more length bytes than needed
         field_len = 0;
         if ($urandom_range(0, 9) == 0)
            field_len = $urandom_range(shortest_length_field(frame_body.size()), MAX_LEN_FIELD);
         send_frame({ptype, flags}, field_len);
      end
   endtask

   function automatic int pick_gap(input bit steady);
      int unsigned r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(6, 30);
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (exp_val !== got_val) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected 0x%0h, got 0x%0h",
                     results_seen, name, exp_val, got_val);
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: present queued bytes, predict each one as it is accepted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_hold  <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_stream_byte(req_tdata, sent_report);
            predicted_reports.push_back(sent_report);
            bytes_accepted++;
         end
         // Slot free: either idle out a gap or load the next byte
         if (!req_tvalid || req_tready) begin
            if (send_hold != 0) begin
               req_tvalid <= 1'b0;
               send_hold  <= send_hold - 1;
            end else if (stream_bytes.size() != 0) begin
               req_tdata  <= stream_bytes.pop_front();
               req_tvalid <= 1'b1;
               send_hold  <= pick_gap(send_steady);
               if ($urandom_range(0, 63) == 0)
                  send_steady <= !send_steady;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: take results with random back-pressure, compare in order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_hold  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (predicted_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: nothing expected, got byte 0x%0h role %0d",
                           results_seen, rsp_tdata[7:0], rsp_tuser);
            end else begin
               want = predicted_reports.pop_front();
               check_field("byte_value",   32'(want.value), 32'(rsp_tdata[7:0]));
               check_field("byte_role",    32'(want.role),  32'(rsp_tuser));
               check_field("packet_type",  32'(want.ptype), 32'(rsp_tdata[11:8]));
               check_field("header_flags", 32'(want.flags), 32'(rsp_tdata[15:12]));
               check_field("rem_length",   32'(want.rlen),  32'(rsp_tdata[43:16]));
               check_field("packet_ident", 32'(want.ident), 32'(rsp_tdata[59:44]));
               check_field("ident_valid",  32'(want.idv),   32'(rsp_tdata[60]));
               check_field("sess_present", 32'(want.sp),    32'(rsp_tdata[61]));
               check_field("ack_code",     32'(want.rc),    32'(rsp_tdata[69:62]));
               check_field("last_of_packet", 32'(want.last), 32'(rsp_tlast));
               check_field("error_code",   32'(want.err),   32'(rsp_tdata[71:70]));
            end
            if (rsp_tlast)
               ends_seen++;
            if (rsp_tdata[60])
               idents_seen++;
            if (rsp_tdata[71:70] == mqttp_pkg::ERR_LEN_LONG)
               long_len_seen++;
            if (rsp_tdata[71:70] == mqttp_pkg::ERR_SHORT)
               short_body_seen++;
         end
         if (recv_hold != 0) begin
            rsp_tready <= 1'b0;
            recv_hold  <= recv_hold - 1;
         end else begin
            rsp_tready <= 1'b1;
            recv_hold  <= pick_gap(recv_steady);
            if ($urandom_range(0, 63) == 0)
               recv_steady <= !recv_steady;
         end
      end
   end

   // Watchdog: end the run when no item moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("stalled: %0d of %0d bytes sent, %0d results still owed",
                  bytes_accepted, bytes_total, predicted_reports.size());
         $display("tb_mqtt_packet_stream_parser_top: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int directed_bytes;

      // CONNACK: session present, then flags byte 0xFE with top return code
      frame_body = '{8'h01, 8'h00};
      send_frame({mqttp_pkg::PT_CONNACK, 4'h0}, 0);
      frame_body = '{8'hFE, 8'hFF};
      send_frame({mqttp_pkg::PT_CONNACK, 4'h0}, 0);
      // CONNACK cut after one body byte, and with no body
      frame_body = '{8'h01};
      send_frame({mqttp_pkg::PT_CONNACK, 4'h0}, 0);
      send_frame({mqttp_pkg::PT_CONNACK, 4'h0}, 0);

      // PUBLISH QoS 0 with topic and payload
      frame_body = '{8'h00, 8'h03, 8'h61, 8'h62, 8'h63, 8'h55, 8'hAA};
      send_frame({mqttp_pkg::PT_PUBLISH, 4'b0000}, 0);
      // PUBLISH QoS 1, dup and retain, empty topic
      frame_body = '{8'h00, 8'h00, 8'h12, 8'h34, 8'hFF};
      send_frame({mqttp_pkg::PT_PUBLISH, 4'b1011}, 0);
      // PUBLISH QoS 3 treated as carrying an id; id ends the packet
      frame_body = '{8'h00, 8'h01, 8'h7F, 8'hFF, 8'hFF};
      send_frame({mqttp_pkg::PT_PUBLISH, 4'b0110}, 0);
      // PUBLISH QoS 2 cut inside the id
      frame_body = '{8'h00, 8'h01, 8'h41, 8'h99};
      send_frame({mqttp_pkg::PT_PUBLISH, 4'b0100}, 0);
      // PUBLISH with largest topic length, cut inside the topic
      frame_body = '{8'hFF, 8'hFF, 8'h00};
      send_frame({mqttp_pkg::PT_PUBLISH, 4'b0000}, 0);
      // PUBLISH cut inside the topic length field
      frame_body = '{8'h80};
      send_frame({mqttp_pkg::PT_PUBLISH, 4'b0001}, 0);

      // Acks: plain, longest length field, flags set, empty, extra codes, cut
      frame_body = '{8'h00, 8'h00};
      send_frame({mqttp_pkg::PT_PUBACK, 4'h0}, 0);
      frame_body = '{8'hFF, 8'hFF};
      send_frame({PT_PUBREC, 4'h0}, MAX_LEN_FIELD);
      frame_body = '{8'hAB, 8'hCD};
      send_frame({PT_PUBREL, 4'h2}, 0);
      send_frame({mqttp_pkg::PT_PUBCOMP, 4'h0}, 0);
      frame_body = '{8'h00, 8'h07, 8'h00, 8'h01, 8'h80};
      send_frame({mqttp_pkg::PT_SUBACK, 4'h0}, 0);
      frame_body = '{8'h42};
      send_frame({mqttp_pkg::PT_UNSUBACK, 4'h0}, 0);

      // Empty bodies on types that allow them; one with a padded length field
      send_frame({PT_PINGREQ, 4'h0}, MAX_LEN_FIELD);
      send_frame({PT_PINGRESP, 4'h0}, 0);
      send_frame({PT_DISCONNECT, 4'h0}, 0);
      // Plain-body types, reserved types at both ends
      push_random_bytes(5);
      send_frame({PT_CONNECT, 4'h0}, 0);
      frame_body = '{8'h11};
      send_frame({PT_RESERVED_LO, 4'h0}, 0);
      frame_body = '{8'h22, 8'h33};
      send_frame({PT_RESERVED_HI, 4'hF}, 0);

      // Runaway length field, then a packet that must parse from a fresh header
      stream_bytes.push_back({mqttp_pkg::PT_PUBLISH, 4'h0});
      repeat (MAX_LEN_FIELD) stream_bytes.push_back(LEN_MORE);
      packets_framed++;
      frame_body = '{8'h00, 8'h01, 8'h00, 8'h01, 8'h61, 8'h00};
      send_frame({PT_SUBSCRIBE, 4'h2}, 0);

      directed_bytes = stream_bytes.size();
      while (stream_bytes.size() < directed_bytes + RANDOM_BYTES)
         add_random_packet();

      // Close with the largest remaining length; the packet stays open
      stream_bytes.push_back({PT_CONNECT, 4'h0});
      repeat (MAX_LEN_FIELD - 1) stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h7F);
      packets_framed++;
      repeat (6) stream_bytes.push_back(8'($urandom));
      bytes_total = stream_bytes.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted != bytes_total)
         @(posedge clock);
      while (predicted_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d stream bytes in %0d packets; %0d results checked, %0d packet ends",
               bytes_total, packets_framed, results_seen, ends_seen);
      $display("seen %0d packet ids, %0d over-long length fields, %0d short bodies",
               idents_seen, long_len_seen, short_body_seen);
      if (mismatches == 0 && predicted_reports.size() == 0) begin
         $display("tb_mqtt_packet_stream_parser_top: done, clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_mqtt_packet_stream_parser_top: done, errors");
      end
      $finish;
   end

endmodule
